[hdl/prl_pkg.sv]
`timescale 1ns / 1ps

package prl_pkg;

    localparam int SAMPLE_W    = 20;
    localparam int SUM_W       = 52;
    localparam int COUNT_W     = 14;
    localparam int RMS_W       = 16;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = (SAMPLE_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PART_W      = SAMPLE_W + DIGIT_W;
    localparam int POS_W       = $clog2(NUM_DIGITS);
    localparam int DIV_STEPS   = SUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int ROOT_W      = SUM_W / 2;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);
    localparam int SQ_REM_W    = ROOT_W + 1;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;

    localparam logic [COUNT_W-1:0] MAX_SAMPLES = COUNT_W'(8192);
    localparam logic [RMS_W-1:0]   RMS_FULL    = RMS_W'(32768);

    typedef enum logic [2:0] {
        ST_ACC,
        ST_WAIT,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } prl_state_t;

    typedef struct packed {
        logic start;
        logic clear;
    } acc_ctl_t;

    typedef struct packed {
        logic busy;
        logic dropped;
    } acc_sts_t;

endpackage

[hdl/prl_sqacc.sv]
`timescale 1ns / 1ps

module prl_sqacc
    import prl_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  acc_ctl_t                   ctl,
    input  logic signed [SAMPLE_W-1:0] sample,
    output acc_sts_t                   sts,
    output logic [SUM_W-1:0]           square_sum,
    output logic [COUNT_W-1:0]         sample_count
);

    logic [SAMPLE_W-1:0] mcand_reg, mcand_next;
    logic [SAMPLE_W-1:0] mplier_reg, mplier_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                busy_reg, busy_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                dropped_reg, dropped_next;
    logic [SAMPLE_W-1:0] mag;
    logic [PART_W-1:0]   partial;
    logic [SUM_W-1:0]    partial_sh;

    // magnitude of the sample, most negative value fits as unsigned
    assign mag        = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;
    assign partial    = PART_W'(mcand_reg) * PART_W'(mplier_reg[DIGIT_W-1:0]);
    assign partial_sh = SUM_W'(partial) << (pos_reg * DIGIT_W);

    always_comb begin
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        pos_next     = pos_reg;
        busy_next    = busy_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (ctl.clear) begin
            sum_next     = '0;
            count_next   = '0;
            dropped_next = 1'b0;
        end else if (ctl.start) begin
            if (count_reg < MAX_SAMPLES) begin
                mcand_next  = mag;
                mplier_next = mag;
                pos_next    = '0;
                busy_next   = 1'b1;
                count_next  = count_reg + COUNT_W'(1);
            end else begin
                dropped_next = 1'b1;
            end
        end else if (busy_reg) begin
            // one 4-bit multiplier digit of the square per cycle, unless clear or start comes first
            sum_next    = sum_reg + partial_sh;
            mplier_next = mplier_reg >> DIGIT_W;
            pos_next    = pos_reg + POS_W'(1);
            if (pos_reg == POS_W'(NUM_DIGITS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        pos_reg    <= pos_next;
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            sum_reg     <= '0;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    assign sts.busy     = busy_reg;
    assign sts.dropped  = dropped_reg;
    assign square_sum   = sum_reg;
    assign sample_count = count_reg;

endmodule

[hdl/prl_div.sv]
`timescale 1ns / 1ps

module prl_div
    import prl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend,
    input  logic [COUNT_W-1:0] divisor,
    output logic               busy,
    output logic [SUM_W-1:0]   quotient
);

    logic [SUM_W-1:0]     dvd_reg, dvd_next;
    logic [COUNT_W-1:0]   dsr_reg, dsr_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 zero_reg, zero_next;
    logic [COUNT_W:0]     rem_sh;
    logic [COUNT_W:0]     rem_diff;
    logic                 ge;

    // restoring division, one quotient bit per cycle shifted in at the bottom
    assign rem_sh   = {rem_reg, dvd_reg[SUM_W-1]};
    assign ge       = rem_sh >= {1'b0, dsr_reg};
    assign rem_diff = rem_sh - {1'b0, dsr_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        if (start) begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
            zero_next = (divisor == '0);
        end else if (busy_reg) begin
            rem_next  = ge ? rem_diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
            dvd_next  = {dvd_reg[SUM_W-2:0], ge};
            step_next = step_reg + DIV_CNT_W'(1);
            if (step_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        zero_reg <= zero_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = zero_reg ? '0 : dvd_reg;

endmodule

[hdl/prl_sqrt.sv]
`timescale 1ns / 1ps

module prl_sqrt
    import prl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] radicand,
    output logic             busy,
    output logic [RMS_W-1:0] rms
);

    logic [SUM_W-1:0]      val_reg, val_next;
    logic [SQ_REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [SQRT_CNT_W-1:0] step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic [SQ_REM_W+1:0]   rem_sh;
    logic [SQ_REM_W+1:0]   trial;
    logic [SQ_REM_W+1:0]   rem_diff;
    logic                  ge;

    // digit-by-digit root, two radicand bits per cycle
    assign rem_sh   = {rem_reg, val_reg[SUM_W-1 -: 2]};
    assign trial    = (SQ_REM_W + 2)'({root_reg, 2'b01});
    assign ge       = rem_sh >= trial;
    assign rem_diff = rem_sh - trial;

    always_comb begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start) begin
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? rem_diff[SQ_REM_W-1:0] : rem_sh[SQ_REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], ge};
            val_next  = val_reg << 2;
            step_next = step_reg + SQRT_CNT_W'(1);
            if (step_reg == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        step_reg <= step_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    // clamp to full scale
    assign busy = busy_reg;
    assign rms  = (root_reg > ROOT_W'(RMS_FULL)) ? RMS_FULL : root_reg[RMS_W-1:0];

endmodule

[hdl/packet_rms_level_core.sv]
`timescale 1ns / 1ps
// sample requests: the next is held off until the 4-bit digit serial squarer (5 digits) is done with the last
// a request dropped past the sample limit does not make the squarer busy
// last sample to result: squaring, divider, root, then handover; no squaring if the sample is dropped
// a finished result waits in the output register while the next packet streams in
// aresetn (synchronous, active low) clears the sum, count, dropped flag and output valid

module packet_rms_level_core
    import prl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [19:0] sample, [23:20] zero
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [15:0] rms
    output logic                 m_tuser    // [0] overflow
);

    prl_state_t         state_reg, state_next;
    acc_ctl_t           acc_ctl;
    acc_sts_t           acc_sts;
    logic [SUM_W-1:0]   square_sum;
    logic [COUNT_W-1:0] sample_count;
    logic [SUM_W-1:0]   mean;
    logic [RMS_W-1:0]   rms;
    logic               div_busy;
    logic               sqrt_busy;
    logic               s_accept;
    logic               div_start;
    logic               sqrt_start;
    logic               out_free;
    logic               out_load;
    logic               ovf_reg, ovf_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [RMS_W-1:0]   rms_reg, rms_next;
    logic               m_ovf_reg, m_ovf_next;

    // squarer and running sum
    prl_sqacc u_sqacc (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (acc_ctl),
        .sample       (s_tdata[SAMPLE_W-1:0]),
        .sts          (acc_sts),
        .square_sum   (square_sum),
        .sample_count (sample_count)
    );

    // mean square, sum over count
    prl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (square_sum),
        .divisor  (sample_count),
        .busy     (div_busy),
        .quotient (mean)
    );

    // root of the mean square, clamped to 1.0
    prl_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (mean),
        .busy     (sqrt_busy),
        .rms      (rms)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACC: begin
                if (s_tvalid && !acc_sts.busy && s_tlast) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!acc_sts.busy) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!div_busy) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (!sqrt_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_tready   = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_ACC:  s_tready   = !acc_sts.busy;
            ST_WAIT: div_start  = !acc_sts.busy;
            ST_DIV:  sqrt_start = !div_busy;
            ST_SQRT: ;
            ST_OUT:  out_load   = out_free;
            default: ;
        endcase
    end

    assign s_accept      = s_tvalid && s_tready;
    assign acc_ctl.start = s_accept;
    // the divider takes the sum at the same edge the accumulator clears
    assign acc_ctl.clear = div_start;

    always_comb begin
        ovf_next      = div_start ? acc_sts.dropped : ovf_reg;
        rms_next      = out_load ? rms : rms_reg;
        m_ovf_next    = out_load ? ovf_reg : m_ovf_reg;
        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        rms_reg   <= rms_next;
        m_ovf_reg <= m_ovf_next;
        ovf_reg   <= ovf_next;
        if (!aresetn) begin
            state_reg    <= ST_ACC;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(rms_reg);
    assign m_tuser  = m_ovf_reg;

    // no sample is taken while the divider or root unit is running
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!div_busy && !sqrt_busy))
        else $error("sample request taken while back end busy");

    // the root unit starts only when the previous state was the division or wait state
    a_sqrt_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_start |-> ($past(state_reg) == ST_DIV || $past(state_reg) == ST_WAIT))
        else $error("root started without a division");

    // a new result appears only from the handover state
    a_out_from_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside handover");

    // level never exceeds full scale
    a_rms_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (rms_reg <= RMS_FULL))
        else $error("rms above full scale");

endmodule
